@@ hdl/i2c_bit_bang_master_top_defines.svh @@
`ifndef I2C_BIT_BANG_MASTER_TOP_DEFINES_SVH
`define I2C_BIT_BANG_MASTER_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define I2CBB_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define I2CBB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/i2cbb_pkg.sv @@
`timescale 1ns / 1ps

package i2cbb_pkg;

	// Command codes.
	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_STOP  = 2'd1,
		OP_WRITE = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	// Phase counts of each command.
	localparam logic [4:0] START_PHASES    = 5'd5;
	localparam logic [4:0] STOP_PHASES     = 5'd4;
	localparam logic [4:0] WRITE_PHASES    = 5'd27;
	localparam logic [4:0] READ_ACK_PHASES = 5'd22;
	localparam logic [4:0] READ_NAK_PHASES = 5'd21;

	// First phase of the write acknowledge bit, and of the read acknowledge.
	localparam logic [4:0] WRITE_ACK_PHASE = 5'd24;
	localparam logic [4:0] READ_ACK_PHASE  = 5'd18;

	localparam logic [15:0] PHASE_TICKS_RST = 16'd100;

	// One command transaction, one tick of the sequencer.
	typedef struct packed {
		logic       cmd_valid;
		logic [1:0] opcode;
		logic [7:0] write_byte;
		logic       send_ack;
		logic       sda_in;
	} cmd_item_t;

	// One result transaction.
	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_byte;
	} res_item_t;

endpackage

@@ hdl/i2cbb_if.sv @@
`timescale 1ns / 1ps

// Command channel: one tick of bus activity per transaction.
interface i2cbb_cmd_if;
	logic       valid;
	logic       ready;
	logic       cmd_valid;
	logic [1:0] opcode;
	logic [7:0] write_byte;
	logic       send_ack;
	logic       sda_in;

	modport source (output valid, cmd_valid, opcode, write_byte, send_ack, sda_in,
		input ready);
	modport sink (input valid, cmd_valid, opcode, write_byte, send_ack, sda_in,
		output ready);
endinterface

// Result channel: line drives and status for one tick.
interface i2cbb_res_if;
	logic       valid;
	logic       ready;
	logic       scl_out;
	logic       sda_out;
	logic       busy_res;
	logic       done_res;
	logic [7:0] read_byte;

	modport source (output valid, scl_out, sda_out, busy_res, done_res, read_byte,
		input ready);
	modport sink (input valid, scl_out, sda_out, busy_res, done_res, read_byte,
		output ready);
endinterface

@@ hdl/i2cbb_seq.sv @@
`timescale 1ns / 1ps

module i2cbb_seq import i2cbb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        adv,
	input  cmd_item_t   item_s1,
	input  logic [15:0] phase_ticks,
	output res_item_t   res_d
);

	logic [4:0]  phase_q;
	logic [1:0]  sub_q;
	logic [15:0] tick_q;
	logic [7:0]  shift_q;
	op_t         op_q;
	logic        ack_q;
	logic        busy_q;
	logic        scl_q;
	logic        sda_q;
	logic [7:0]  rd_q;

	logic [4:0]  phase_d;
	logic [1:0]  sub_d;
	logic [15:0] tick_d;
	logic [7:0]  shift_d;
	op_t         op_d;
	logic        ack_d;
	logic        busy_d;
	logic        scl_d;
	logic        sda_d;
	logic [7:0]  rd_d;
	logic        done_d;

	logic [15:0] limit;
	logic [15:0] tick_inc;
	logic        phase_end;
	logic [4:0]  phase_nxt;
	logic [1:0]  sub_nxt;
	logic [4:0]  phase_cnt;
	logic [7:0]  shift_adv;

	// Line levels on entry to a phase: each phase moves one line.
	function automatic logic [1:0] enter_phase(op_t op, logic ack, logic [4:0] p,
		logic [1:0] sub, logic msb, logic scl, logic sda);
		logic s_scl;
		logic s_sda;
		s_scl = scl;
		s_sda = sda;
		case (op)
			OP_START: begin
				case (p)
					5'd0: s_scl = 1'b0;
					5'd1: s_sda = 1'b1;
					5'd2: s_scl = 1'b1;
					5'd3: s_sda = 1'b0;
					5'd4: s_scl = 1'b0;
					default: ;
				endcase
			end
			OP_STOP: begin
				case (p)
					5'd0: s_scl = 1'b0;
					5'd1: s_sda = 1'b0;
					5'd2: s_scl = 1'b1;
					5'd3: s_sda = 1'b1;
					default: ;
				endcase
			end
			OP_WRITE: begin
				case (sub)
					2'd0: s_sda = (p >= WRITE_ACK_PHASE) ? 1'b1 : msb;
					2'd1: s_scl = 1'b1;
					default: s_scl = 1'b0;
				endcase
			end
			default: begin
				if (p == 5'd0) begin
					s_sda = 1'b1;
				end else if (p == 5'd1) begin
					s_scl = 1'b0;
				end else if (p < READ_ACK_PHASE) begin
					s_scl = ~p[0];
				end else if (ack) begin
					case (p)
						5'd18: s_sda = 1'b0;
						5'd19: s_scl = 1'b1;
						5'd20: s_scl = 1'b0;
						default: s_sda = 1'b1;
					endcase
				end else begin
					case (p)
						5'd18: s_sda = 1'b1;
						5'd19: s_scl = 1'b1;
						default: s_scl = 1'b0;
					endcase
				end
			end
		endcase
		return {s_scl, s_sda};
	endfunction

	// Phase timing: a zero setting counts as one tick per phase.
	assign limit     = (phase_ticks == '0) ? 16'd1 : phase_ticks;
	assign tick_inc  = tick_q + 16'd1;
	assign phase_end = ({1'b0, tick_inc} + 17'd1) >= {1'b0, limit};
	assign phase_nxt = phase_q + 5'd1;
	assign sub_nxt   = (sub_q == 2'd2) ? 2'd0 : sub_q + 2'd1;

	// Number of phases of the running command.
	always_comb begin
		case (op_q)
			OP_START: phase_cnt = START_PHASES;
			OP_STOP:  phase_cnt = STOP_PHASES;
			OP_WRITE: phase_cnt = WRITE_PHASES;
			default:  phase_cnt = ack_q ? READ_ACK_PHASES : READ_NAK_PHASES;
		endcase
	end

	// Shift register at the end of a phase: sample on read SCL-high, shift on write.
	always_comb begin
		shift_adv = shift_q;
		if (op_q == OP_READ && phase_q inside {[5'd2:5'd17]} && !phase_q[0]) begin
			shift_adv = {shift_q[6:0], item_s1.sda_in};
		end
		if (op_q == OP_WRITE && phase_q < WRITE_ACK_PHASE && sub_q == 2'd2) begin
			shift_adv = {shift_q[6:0], 1'b0};
		end
	end

	// Next state for one tick.
	always_comb begin
		phase_d = phase_q;
		sub_d   = sub_q;
		tick_d  = tick_q;
		shift_d = shift_q;
		op_d    = op_q;
		ack_d   = ack_q;
		busy_d  = busy_q;
		scl_d   = scl_q;
		sda_d   = sda_q;
		rd_d    = rd_q;
		done_d  = 1'b0;
		if (busy_q) begin
			tick_d = tick_inc;
			if (phase_end) begin
				shift_d = shift_adv;
				phase_d = phase_nxt;
				sub_d   = sub_nxt;
				tick_d  = '0;
				if (phase_nxt >= phase_cnt) begin
					busy_d = 1'b0;
					done_d = 1'b1;
					if (op_q == OP_READ) begin
						rd_d = shift_adv;
					end
				end else begin
					{scl_d, sda_d} = enter_phase(op_q, ack_q, phase_nxt, sub_nxt,
						shift_adv[7], scl_q, sda_q);
				end
			end
		end else if (item_s1.cmd_valid) begin
			op_d    = op_t'(item_s1.opcode);
			ack_d   = item_s1.send_ack;
			shift_d = (op_t'(item_s1.opcode) == OP_WRITE) ? item_s1.write_byte : 8'd0;
			phase_d = '0;
			sub_d   = '0;
			tick_d  = '0;
			busy_d  = 1'b1;
			{scl_d, sda_d} = enter_phase(op_t'(item_s1.opcode), item_s1.send_ack, 5'd0,
				2'd0, item_s1.write_byte[7], scl_q, sda_q);
		end
	end

	// Sequencer state, updated once per accepted tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			sub_q   <= '0;
			tick_q  <= '0;
			shift_q <= '0;
			op_q    <= OP_START;
			ack_q   <= 1'b0;
			busy_q  <= 1'b0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			rd_q    <= '0;
		end else if (adv) begin
			phase_q <= phase_d;
			sub_q   <= sub_d;
			tick_q  <= tick_d;
			shift_q <= shift_d;
			op_q    <= op_d;
			ack_q   <= ack_d;
			busy_q  <= busy_d;
			scl_q   <= scl_d;
			sda_q   <= sda_d;
			rd_q    <= rd_d;
		end
	end

	// Result of this tick.
	assign res_d.scl_out   = scl_d;
	assign res_d.sda_out   = sda_d;
	assign res_d.busy_res  = busy_d;
	assign res_d.done_res  = done_d;
	assign res_d.read_byte = rd_d;

endmodule

@@ hdl/i2c_bit_bang_master_top.sv @@
`timescale 1ns / 1ps

// Open-drain I2C master sequencer stepped by command transactions: every accepted
// transaction is one bus tick and returns exactly one result transaction with the
// SCL and SDA drives, busy, done and the last read byte. Transactions are taken one
// per clock cycle while the result side is not stalled; a transaction goes through
// an input register and the sequencer's combinational next-state logic into the
// result register, which offers its result. Each bus phase lasts one tick less
// than phase_ticks, but at least one tick (zero counts as one). Commands arriving
// while busy are ignored. Write phase_ticks only while no transaction is in flight.
module i2c_bit_bang_master_top import i2cbb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	i2cbb_cmd_if.sink   cmd,
	i2cbb_res_if.source res,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	cmd_item_t   item_s1;
	logic        vld_s1;
	res_item_t   res_d;
	res_item_t   res_q;
	logic        res_vld_q;
	logic        adv;
	logic [15:0] phase_ticks_q;

	// The stage advances when it holds a transaction and the result register is free or being emptied.
	assign adv       = vld_s1 && (!res_vld_q || res.ready);
	assign cmd.ready = !vld_s1 || adv;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_ticks_q <= PHASE_TICKS_RST;
		end else if (cfg_we) begin
			phase_ticks_q <= cfg_wdata;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (cmd.valid && cmd.ready) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			item_s1 <= '{cmd_valid: cmd.cmd_valid, opcode: cmd.opcode,
				write_byte: cmd.write_byte, send_ack: cmd.send_ack, sda_in: cmd.sda_in};
		end
	end

	// Bus sequencer.
	i2cbb_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.item_s1     (item_s1),
		.phase_ticks (phase_ticks_q),
		.res_d       (res_d)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (adv) begin
			res_vld_q <= 1'b1;
		end else if (res.ready) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_d;
		end
	end

	assign res.valid     = res_vld_q;
	assign res.scl_out   = res_q.scl_out;
	assign res.sda_out   = res_q.sda_out;
	assign res.busy_res  = res_q.busy_res;
	assign res.done_res  = res_q.done_res;
	assign res.read_byte = res_q.read_byte;

endmodule

@@ hdl/i2cbb_checker.sv @@
`timescale 1ns / 1ps
`include "i2c_bit_bang_master_top_defines.svh"

module i2cbb_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       cmd_ready,
	input logic       res_valid,
	input logic       res_ready,
	input logic       res_busy,
	input logic       res_done,
	input logic [7:0] res_byte
);

	// A stalled result holds its value.
	`I2CBB_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(res_busy) && $stable(res_done) && $stable(res_byte), "result changed while stalled")

	// A completing tick leaves the sequencer idle.
	`I2CBB_ASSERT_NOW(a_done_idle, clk, arst_n, res_valid && res_done, !res_busy, "done with busy still set")

	// The tick after a completion cannot complete again.
	`I2CBB_ASSERT_NEXT(a_done_once, clk, arst_n, res_valid && res_ready && res_done, !(res_valid && res_done), "two completions in a row")

	// A drained output never holds back the command side.
	`I2CBB_ASSERT_NOW(a_no_bubble, clk, arst_n, res_ready, cmd_ready, "command stalled with result side ready")

endmodule

bind i2c_bit_bang_master_top i2cbb_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_ready (cmd.ready),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_busy  (res.busy_res),
	.res_done  (res.done_res),
	.res_byte  (res.read_byte)
);
